/* rtl/tlpte_pkg.sv */
package tlpte_pkg;

   localparam logic [31:0] FRAME_MASK   = 32'hFFFFF000;
   localparam logic [31:0] BIT_PRESENT  = 32'h1;
   localparam logic [31:0] BIT_WRITABLE = 32'h2;
   localparam logic [31:0] BIT_USER     = 32'h4;
   localparam logic [9:0]  SELF_SLOT    = 10'd1023;

   localparam logic [1:0] REQ_MAP       = 2'd0;
   localparam logic [1:0] REQ_UNMAP     = 2'd1;
   localparam logic [1:0] REQ_TRANSLATE = 2'd2;
   localparam logic [1:0] REQ_TEST      = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_MISALIGNED = 3'd1;
   localparam logic [2:0] ST_RESERVED   = 3'd2;
   localparam logic [2:0] ST_NO_FRAME   = 3'd3;
   localparam logic [2:0] ST_NOT_PRES   = 3'd4;
   localparam logic [2:0] ST_MAPPED     = 3'd5;

   localparam logic [1:0] CSR_DIR_FRAME   = 2'd0;
   localparam logic [1:0] CSR_FIRST_FRAME = 2'd1;
   localparam logic [1:0] CSR_FLAG_MASK   = 2'd2;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_DIR_RD,
      S_TBL_RD,
      S_CLEAR,
      S_EXEC,
      S_OUT
   } state_type;

endpackage

/* rtl/two_level_page_table_engine_core.sv */
// Two-level x86-style page table engine. After reset a clearing pass over
// max(DIR_ENTRIES, TABLE_ENTRIES) entries (1024 by default) zeroes the directory
// memory and loads table zero with the identity map; req_tready stays low
// meanwhile. A request word is accepted in idle, then passes through the
// directory read, table read and execute states; the result is registered in
// the rsp_ register at execute, and the next word is taken only after the
// output state and once the response has been taken while rsp_tready is high.
// A map that installs a new table passes through a clear state that zeroes it.
// Directory and tables live in two single-port synchronous memories; directory
// entry zero is kept in registers and entry 1023 is derived from
// directory_frame. One request is in flight at a time.
module two_level_page_table_engine_core
   import tlpte_pkg::*;
#(
   parameter int DIR_ENTRIES   = 1024,
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [1:0] req_type, [33:2] virt_addr, [65:34] phys_addr, [77:66] map_flags,
   // [78] hand_back, [110:79] offered_table_frame, [111] zero
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] ok, [3:1] status, [35:4] phys_out, [36] frame_released,
   // [37] table_frame_taken, [39:38] zero
   output logic [39:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int DW     = $clog2(DIR_ENTRIES);
   localparam int TW     = $clog2(TABLE_ENTRIES);
   localparam int CW     = (DW > TW ? DW : TW) + 1;
   localparam int INIT_N = DIR_ENTRIES > TABLE_ENTRIES ? DIR_ENTRIES : TABLE_ENTRIES;

   logic [31:0] dir_mem [DIR_ENTRIES];
   logic [31:0] tbl_mem [2**(DW+TW)];

   state_type state_ff, state_in;
   logic [1:0]  type_ff;
   logic [31:0] va_ff, pa_ff, offer_ff;
   logic [11:0] flags_ff;
   logic        rel_ff;
   logic [31:0] dir_frame_ff, first_frame_ff;
   logic [11:0] mask_ff;
   logic [11:0] dir0_flags_ff;
   logic [CW-1:0] clr_cnt_ff;
   logic [31:0] dir_rd_ff, tbl_rd_ff;
   logic [39:0] rsp_ff;
   logic        rsp_valid_ff;
   logic        taken_ff;

   logic [9:0] d_idx, t_idx;
   logic       d_ok, t_ok, self_slot, aligned_va, aligned_pa;
   logic [DW-1:0] d_a;
   logic [TW-1:0] t_a;

   assign d_idx      = va_ff[31:22];
   assign t_idx      = va_ff[21:12];
   assign d_ok       = 32'(d_idx) < 32'(DIR_ENTRIES);
   assign t_ok       = 32'(t_idx) < 32'(TABLE_ENTRIES);
   assign self_slot  = d_idx == SELF_SLOT;
   assign aligned_va = va_ff[11:0] == 12'd0;
   assign aligned_pa = pa_ff[11:0] == 12'd0;
   assign d_a        = d_idx[DW-1:0];
   assign t_a        = t_idx[TW-1:0];

   assign req_tready = state_ff == S_IDLE && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // effective directory entry (after read latency)
   logic [31:0] dir_eff, self_e;
   assign self_e = (dir_frame_ff & FRAME_MASK) | BIT_WRITABLE | BIT_PRESENT;
   always_comb begin
      if (self_slot) dir_eff = self_e;
      else if (!d_ok) dir_eff = 32'd0;
      else if (d_a == '0) dir_eff = (first_frame_ff & FRAME_MASK) | 32'(dir0_flags_ff);
      else dir_eff = dir_rd_ff;
   end

   // effective table entry; for the recursive slot: directory entry at t
   logic [31:0] tbl_eff;
   logic [DW-1:0] t_as_d;
   assign t_as_d = t_idx[DW-1:0];
   always_comb begin
      if (self_slot) begin
         if (t_idx == SELF_SLOT) tbl_eff = self_e;
         else if (32'(t_idx) >= 32'(DIR_ENTRIES)) tbl_eff = 32'd0;
         else if (t_as_d == '0) tbl_eff = (first_frame_ff & FRAME_MASK) | 32'(dir0_flags_ff);
         else tbl_eff = dir_rd_ff;
      end else if (!d_ok || !t_ok) tbl_eff = 32'd0;
      else tbl_eff = tbl_rd_ff;
   end

   logic [DW+TW-1:0] tbl_addr;
   assign tbl_addr = {d_a, t_a};

   logic [31:0] init_e;
   assign init_e = ((32'(clr_cnt_ff) << 12) & FRAME_MASK) | BIT_WRITABLE | BIT_PRESENT;

   always_ff @(posedge clock) begin
      if (state_ff == S_DIR_RD) dir_rd_ff <= dir_mem[self_slot ? t_as_d : d_a];
      if (state_ff == S_TBL_RD) tbl_rd_ff <= tbl_mem[tbl_addr];
   end

   // execute decode
   logic [2:0]  st;
   logic        ok, rel_o, need_clear;
   logic [31:0] phys;
   logic        dir_wr, tbl_wr;
   logic [31:0] dir_wd, tbl_wd;
   logic [31:0] tcur;
   assign tcur = taken_ff ? 32'd0 : tbl_eff;

   always_comb begin
      st = ST_OK; ok = 1'b0; phys = 32'd0; rel_o = 1'b0; need_clear = 1'b0;
      dir_wr = 1'b0; tbl_wr = 1'b0; dir_wd = 32'd0; tbl_wd = 32'd0;
      case (type_ff)
         REQ_MAP: begin
            if (!aligned_va || !aligned_pa) st = ST_MISALIGNED;
            else if (self_slot || !d_ok || !t_ok) st = ST_RESERVED;
            else if (!taken_ff && !dir_eff[0]) begin
               if (offer_ff == 32'd0) st = ST_NO_FRAME;
               else need_clear = 1'b1;
            end else begin
               if (!taken_ff) begin
                  dir_wr = 1'b1;
                  dir_wd = dir_eff | BIT_WRITABLE | (32'(flags_ff) & BIT_USER);
               end
               if (tcur[0]) st = ST_MAPPED;
               else begin
                  tbl_wr = 1'b1;
                  tbl_wd = (pa_ff & FRAME_MASK) | BIT_PRESENT | 32'(flags_ff & mask_ff);
                  ok = 1'b1;
               end
            end
         end
         REQ_UNMAP: begin
            if (!aligned_va) st = ST_MISALIGNED;
            else if (self_slot) st = ST_RESERVED;
            else if (!dir_eff[0] || !tbl_eff[0]) st = ST_NOT_PRES;
            else begin
               tbl_wr = 1'b1; phys = tbl_eff & FRAME_MASK; rel_o = rel_ff; ok = 1'b1;
            end
         end
         default: begin
            if (!dir_eff[0] || !tbl_eff[0]) st = ST_NOT_PRES;
            else begin
               phys = (tbl_eff & FRAME_MASK) + {20'd0, va_ff[11:0]}; ok = 1'b1;
            end
         end
      endcase
   end

   logic [31:0] new_dir_e;
   assign new_dir_e = (offer_ff & FRAME_MASK) | BIT_WRITABLE | BIT_PRESENT
                      | (32'(flags_ff) & BIT_USER);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT:   if (clr_cnt_ff == CW'(INIT_N - 1)) state_in = S_IDLE;
         S_IDLE:   if (req_tvalid && req_tready) state_in = S_DIR_RD;
         S_DIR_RD: state_in = S_TBL_RD;
         S_TBL_RD: state_in = need_clear ? S_CLEAR : S_EXEC;
         S_CLEAR:  if (clr_cnt_ff == CW'(TABLE_ENTRIES - 1)) state_in = S_EXEC;
         S_EXEC:   state_in = S_OUT;
         S_OUT:    state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_INIT) begin
         if (clr_cnt_ff < CW'(DIR_ENTRIES)) dir_mem[clr_cnt_ff[DW-1:0]] <= 32'd0;
         if (clr_cnt_ff < CW'(TABLE_ENTRIES))
            tbl_mem[{{DW{1'b0}}, clr_cnt_ff[TW-1:0]}] <= init_e;
      end else begin
         if (state_ff == S_CLEAR) tbl_mem[{d_a, clr_cnt_ff[TW-1:0]}] <= 32'd0;
         else if (state_ff == S_EXEC && tbl_wr) tbl_mem[tbl_addr] <= tbl_wd;
         if (state_ff == S_TBL_RD && type_ff == REQ_MAP && need_clear) dir_mem[d_a] <= new_dir_e;
         else if (state_ff == S_EXEC && dir_wr) dir_mem[d_a] <= dir_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_INIT;
         rsp_valid_ff   <= 1'b0;
         dir_frame_ff   <= 32'd0;
         first_frame_ff <= 32'd4096;
         mask_ff        <= 12'hFFF;
         dir0_flags_ff  <= 12'h003;
         taken_ff       <= 1'b0;
         clr_cnt_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_DIR_FRAME:   dir_frame_ff <= csr_wdata;
               CSR_FIRST_FRAME: first_frame_ff <= csr_wdata;
               CSR_FLAG_MASK:   mask_ff <= csr_wdata[11:0];
               default: ;
            endcase
         end
         if (state_ff == S_IDLE && req_tvalid && req_tready) begin
            type_ff  <= req_tdata[1:0];
            va_ff    <= req_tdata[33:2];
            pa_ff    <= req_tdata[65:34];
            flags_ff <= req_tdata[77:66];
            rel_ff   <= req_tdata[78];
            offer_ff <= req_tdata[110:79];
            taken_ff <= 1'b0;
         end
         if (state_ff == S_TBL_RD && need_clear) begin
            taken_ff   <= 1'b1;
            clr_cnt_ff <= '0;
            if (d_a == '0) begin
               first_frame_ff <= offer_ff;
               dir0_flags_ff  <= new_dir_e[11:0];
            end
         end
         if (state_ff == S_INIT || state_ff == S_CLEAR) clr_cnt_ff <= clr_cnt_ff + CW'(1);
         if (state_ff == S_EXEC) begin
            if (dir_wr && d_a == '0) dir0_flags_ff <= dir_wd[11:0];
            rsp_ff       <= {2'b00, taken_ff, rel_o, phys, st, ok};
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   property p_no_accept_busy;
      @(posedge clock) disable iff (reset) (state_ff != S_IDLE) |-> !req_tready;
   endproperty
   a_no_accept_busy: assert property (p_no_accept_busy) else $error("busy accept");

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |=> rsp_tvalid) else $error("no rsp");

   a_taken_map_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && taken_ff) |-> type_ff == REQ_MAP) else $error("taken");

endmodule

/* dv/testbench.sv */
module testbench;
   import tlpte_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] va;
      logic [31:0] pa;
      logic [11:0] flags;
      logic        rel;
      logic [31:0] offer;
   } page_req_type;

   typedef struct {
      logic        ok;
      logic [2:0]  status;
      logic [31:0] phys;
      logic        released;
      logic        taken;
   } page_rsp_type;

   class page_table_scoreboard;
      logic [31:0] dir_frame;
      logic [31:0] first_frame;
      logic [11:0] flag_mask;
      logic [31:0] dir_ent [1024];
      logic [31:0] tbl_ent [1048576];
      page_rsp_type expected_q[$];
      int          errors;

      function new();
         dir_frame   = 32'h0;
         first_frame = 32'h1000;
         flag_mask   = 12'hFFF;
         errors      = 0;
         foreach (dir_ent[i]) dir_ent[i] = 32'h0;
         foreach (tbl_ent[i]) tbl_ent[i] = 32'h0;
         dir_ent[0] = (first_frame & FRAME_MASK) | BIT_WRITABLE | BIT_PRESENT;
         for (int i = 0; i < 1024; i++)
            tbl_ent[i] = ((i * 4096) & FRAME_MASK) | BIT_WRITABLE | BIT_PRESENT;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] value);
         if (idx == CSR_DIR_FRAME) begin
            dir_frame = value;
         end else if (idx == CSR_FIRST_FRAME) begin
            first_frame = value;
            dir_ent[0] = (dir_ent[0] & 32'hFFF) | (value & FRAME_MASK);
         end else if (idx == CSR_FLAG_MASK) begin
            flag_mask = value[11:0];
         end
      endfunction

      function logic [31:0] dir_lookup(logic [9:0] d);
         if (d == SELF_SLOT) return (dir_frame & FRAME_MASK) | BIT_WRITABLE | BIT_PRESENT;
         return dir_ent[d];
      endfunction

      function logic [31:0] tbl_lookup(logic [9:0] d, logic [9:0] t);
         if (d == SELF_SLOT) return dir_lookup(t);
         return tbl_ent[{d, t}];
      endfunction

      function page_rsp_type walk(page_req_type r);
         page_rsp_type o;
         logic [9:0]  d;
         logic [9:0]  t;
         logic [31:0] e;
         logic        have;
         o = '{ok: 0, status: ST_OK, phys: 0, released: 0, taken: 0};
         d = r.va[31:22];
         t = r.va[21:12];
         if (r.kind == REQ_MAP) begin
            if (r.va[11:0] != 0 || r.pa[11:0] != 0) begin
               o.status = ST_MISALIGNED;
            end else if (d == SELF_SLOT) begin
               o.status = ST_RESERVED;
            end else begin
               have = 1;
               if ((dir_ent[d] & BIT_PRESENT) == 0) begin
                  if (r.offer == 0) begin
                     o.status = ST_NO_FRAME;
                     have = 0;
                  end else begin
                     e = (r.offer & FRAME_MASK) | BIT_WRITABLE | BIT_PRESENT;
                     if (r.flags[2]) e |= BIT_USER;
                     dir_ent[d] = e;
                     for (int i = 0; i < 1024; i++) tbl_ent[{d, 10'(i)}] = 32'h0;
                     o.taken = 1;
                  end
               end else begin
                  if (r.flags[2]) dir_ent[d] |= BIT_USER;
                  dir_ent[d] |= BIT_WRITABLE;
               end
               if (have) begin
                  if ((tbl_ent[{d, t}] & BIT_PRESENT) != 0) begin
                     o.status = ST_MAPPED;
                  end else begin
                     tbl_ent[{d, t}] = (r.pa & FRAME_MASK) | BIT_PRESENT
                                       | {20'h0, r.flags & flag_mask};
                     o.ok = 1;
                  end
               end
            end
         end else if (r.kind == REQ_UNMAP) begin
            if (r.va[11:0] != 0) begin
               o.status = ST_MISALIGNED;
            end else if (d == SELF_SLOT) begin
               o.status = ST_RESERVED;
            end else if ((dir_lookup(d) & BIT_PRESENT) == 0
                         || (tbl_lookup(d, t) & BIT_PRESENT) == 0) begin
               o.status = ST_NOT_PRES;
            end else begin
               e = tbl_lookup(d, t);
               tbl_ent[{d, t}] = 32'h0;
               o.phys = e & FRAME_MASK;
               o.released = r.rel;
               o.ok = 1;
            end
         end else begin
            if ((dir_lookup(d) & BIT_PRESENT) == 0
                || (tbl_lookup(d, t) & BIT_PRESENT) == 0) begin
               o.status = ST_NOT_PRES;
            end else begin
               o.phys = (tbl_lookup(d, t) & FRAME_MASK) + {20'h0, r.va[11:0]};
               o.ok = 1;
            end
         end
         return o;
      endfunction

      function void note_request(page_req_type r);
         expected_q.push_back(walk(r));
      endfunction

      function void check_response(logic [39:0] w);
         page_rsp_type x;
         if (expected_q.size() == 0) begin
            $error("response word with nothing expected: %h", w);
            errors++;
            return;
         end
         x = expected_q.pop_front();
         if (w[0] !== x.ok) begin
            $error("ok: expected %0d actual %0d", x.ok, w[0]);
            errors++;
         end
         if (w[3:1] !== x.status) begin
            $error("status: expected %0d actual %0d", x.status, w[3:1]);
            errors++;
         end
         if (w[35:4] !== x.phys) begin
            $error("phys_out: expected %h actual %h", x.phys, w[35:4]);
            errors++;
         end
         if (w[36] !== x.released) begin
            $error("frame_released: expected %0d actual %0d", x.released, w[36]);
            errors++;
         end
         if (w[37] !== x.taken) begin
            $error("table_frame_taken: expected %0d actual %0d", x.taken, w[37]);
            errors++;
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [111:0]  req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [39:0]   rsp_tdata;
   logic          csr_we;
   logic [1:0]    csr_index;
   logic [31:0]   csr_wdata;

   page_table_scoreboard sb;
   int idle_cycles;
   int stall_mode;
   int cycle_count;

   two_level_page_table_engine_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver stall pattern: a randomly picked mode holds rsp_tready high, random or rarely high
   always @(negedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("two_level_page_table_engine_core: mismatch");
            $finish;
         end
      end
   end

   task automatic send_word(page_req_type r);
      @(negedge clock);
      req_tdata  <= {1'b0, r.offer, r.rel, r.flags, r.pa, r.va, r.kind};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
   endtask

   task automatic pause_sender(int n);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      pause_sender(0);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic page_req_type make_req(logic [1:0] k, logic [31:0] va, logic [31:0] pa,
                                             logic [11:0] fl, logic rl, logic [31:0] of);
      page_req_type r;
      r.kind = k; r.va = va; r.pa = pa; r.flags = fl; r.rel = rl; r.offer = of;
      return r;
   endfunction

   function automatic page_req_type random_req();
      page_req_type r;
      logic [9:0]  d;
      logic [9:0]  t;
      logic [11:0] off;
      int          pick;
      pick = $urandom_range(0, 99);
      r.kind = pick < 35 ? REQ_MAP : pick < 55 ? REQ_UNMAP : pick < 80 ? REQ_TRANSLATE : REQ_TEST;
      case ($urandom_range(0, 7))
         0, 1: d = 10'd0;
         2:    d = 10'd1;
         3:    d = 10'd2;
         4:    d = SELF_SLOT;
         5:    d = 10'd1022;
         default: d = 10'($urandom_range(0, 1023));
      endcase
      case ($urandom_range(0, 5))
         0: t = 10'd0;
         1: t = 10'd1;
         2: t = 10'd1023;
         3: t = 10'($urandom_range(0, 7));
         default: t = 10'($urandom_range(0, 1023));
      endcase
      off = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'h0;
      if (r.kind >= REQ_TRANSLATE) off = 12'($urandom);
      r.va    = {d, t, off};
      r.pa    = $urandom;
      if ($urandom_range(0, 9) != 0) r.pa[11:0] = 12'h0;
      r.flags = 12'($urandom);
      r.rel   = 1'($urandom_range(0, 1));
      r.offer = $urandom;
      if (r.offer > 32'hFFFFF000) r.offer &= FRAME_MASK;
      if ($urandom_range(0, 6) == 0) r.offer = 32'h0;
      return r;
   endfunction

   initial begin
      int          burst;
      logic [31:0] cfg_dir [4];
      logic [31:0] cfg_first [4];
      logic [11:0] cfg_mask [4];
      sb = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_we      = 1'b0;
      csr_index   = CSR_DIR_FRAME;
      csr_wdata   = '0;
      idle_cycles = 0;
      stall_mode  = 0;
      cycle_count = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_word(make_req(REQ_MAP, 32'h0000_1000, 32'h0005_0000, 12'h003, 1'b0, 32'h0));
      send_word(make_req(REQ_MAP, 32'h0040_0004, 32'h0005_0000, 12'h003, 1'b0, 32'h0007_0000));
      send_word(make_req(REQ_MAP, 32'h0040_0000, 32'h0005_0001, 12'h003, 1'b0, 32'h0007_0000));
      send_word(make_req(REQ_MAP, 32'hFFC0_0000, 32'h0005_0000, 12'h003, 1'b0, 32'h0007_0000));
      send_word(make_req(REQ_MAP, 32'h0040_0000, 32'h0005_0000, 12'h003, 1'b0, 32'h0));
      send_word(make_req(REQ_MAP, 32'h0040_0000, 32'hFFFF_F000, 12'hFFF, 1'b0, 32'hFFFF_F000));
      send_word(make_req(REQ_TRANSLATE, 32'h0040_0FFF, 32'h0, 12'h0, 1'b0, 32'h0));
      send_word(make_req(REQ_TEST, 32'h0040_0000, 32'h0, 12'h0, 1'b0, 32'h0));
      send_word(make_req(REQ_MAP, 32'h0040_0000, 32'h0001_0000, 12'h004, 1'b0, 32'h0));
      send_word(make_req(REQ_MAP, 32'h007F_F000, 32'h0000_0000, 12'h000, 1'b0, 32'h0));
      send_word(make_req(REQ_UNMAP, 32'h0040_0000, 32'h0, 12'h0, 1'b1, 32'h0));
      send_word(make_req(REQ_UNMAP, 32'h0040_0000, 32'h0, 12'h0, 1'b1, 32'h0));
      send_word(make_req(REQ_UNMAP, 32'h0000_0000, 32'h0, 12'h0, 1'b0, 32'h0));
      send_word(make_req(REQ_UNMAP, 32'hFFC0_1000, 32'h0, 12'h0, 1'b1, 32'h0));
      send_word(make_req(REQ_UNMAP, 32'h0000_2008, 32'h0, 12'h0, 1'b1, 32'h0));
      send_word(make_req(REQ_TRANSLATE, 32'hFFC0_0123, 32'h0, 12'h0, 1'b0, 32'h0));
      send_word(make_req(REQ_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 12'h0, 1'b0, 32'h0));
      send_word(make_req(REQ_TEST, 32'hFFFF_E000, 32'h0, 12'h0, 1'b0, 32'h0));
      send_word(make_req(REQ_TRANSLATE, 32'h8000_0000, 32'h0, 12'h0, 1'b0, 32'h0));
      send_word(make_req(REQ_TEST, 32'h003F_FABC, 32'h0, 12'h0, 1'b0, 32'h0));
      drain();

      cfg_dir   = '{32'hFFFF_F000, 32'h0, 32'h0012_3000, 32'h0};
      cfg_first = '{32'h0, 32'hFFFF_F000, 32'h0000_2000, 32'h0000_1000};
      cfg_mask  = '{12'h000, 12'hFFF, 12'h5A6, 12'h006};
      for (int ph = 0; ph < 5; ph++) begin
         if (ph < 4) begin
            write_csr(CSR_DIR_FRAME, cfg_dir[ph]);
            write_csr(CSR_FIRST_FRAME, cfg_first[ph]);
            write_csr(CSR_FLAG_MASK, {20'h0, cfg_mask[ph]});
         end else begin
            write_csr(CSR_DIR_FRAME, $urandom & FRAME_MASK);
            write_csr(CSR_FIRST_FRAME, $urandom & FRAME_MASK);
            write_csr(CSR_FLAG_MASK, 32'($urandom_range(0, 4095)));
         end
         for (int n = 0; n < 230; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < 230; b++, n++) send_word(random_req());
            if (n == 115 && ph == 2) drain();
            else if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(0, 8));
         end
         drain();
      end

      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("two_level_page_table_engine_core: match");
      end else begin
         $display("two_level_page_table_engine_core: mismatch");
      end
      $finish;
   end
endmodule

/* sim.f */
rtl/tlpte_pkg.sv
rtl/two_level_page_table_engine_core.sv
dv/testbench.sv
